### design/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and codes for the packed pixel plane editor.
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

    // Command codes carried by a transaction
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CYCLE = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COORD = 2'd1;
    localparam logic [1:0] ST_VALUE = 2'd2;
    localparam logic [1:0] ST_DIMS  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Shift of the first (MSB-side) pixel field within a byte for each pixel depth
    localparam logic [2:0] SHIFT_BASE_HIRES = 3'd7;
    localparam logic [2:0] SHIFT_BASE_MULTI = 3'd6;

    // Byte update request handed to the pixel unit
    typedef struct packed {
        cmd_t       cmd;
        logic       multicolor;
        logic [2:0] shift;
        logic [1:0] value;
    } px_op_t;

endpackage

`default_nettype wire

### design/ppe_ram.sv
// ----------------------------------------------------------------------------
// ppe_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write-first is not needed; read returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### design/ppe_pixel_alu.sv
// ----------------------------------------------------------------------------
// ppe_pixel_alu
// Extracts one pixel from a packed byte and builds the updated byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_pixel_alu (
    input  wire ppe_pkg::px_op_t op,
    input  wire logic [7:0]      byte_in,
    output logic      [7:0]      byte_out,
    output logic      [1:0]      pixel,
    output logic                 write_back
);

    logic [1:0] pix_mask;
    logic [7:0] field_mask;
    logic [7:0] shifted;
    logic [1:0] cur_pix;
    logic [1:0] new_pix;

    // Field extraction, MSB-first packing
    always_comb
    begin
        pix_mask   = op.multicolor ? 2'b11 : 2'b01;
        field_mask = {6'd0, pix_mask} << op.shift;
        shifted    = byte_in >> op.shift;
        cur_pix    = shifted[1:0] & pix_mask;
    end

    // New pixel value per command
    always_comb
    begin
        unique case (op.cmd)
            ppe_pkg::CMD_READ:  new_pix = cur_pix;
            ppe_pkg::CMD_WRITE: new_pix = op.value & pix_mask;
            ppe_pkg::CMD_CYCLE: new_pix = (cur_pix + 2'd1) & pix_mask;
            ppe_pkg::CMD_CLEAR: new_pix = 2'd0;
            default:            new_pix = 2'd0;
        endcase
    end

    // Merge back into the byte
    always_comb
    begin
        byte_out   = (byte_in & ~field_mask) | (({6'd0, new_pix} << op.shift) & field_mask);
        pixel      = new_pix;
        write_back = (op.cmd == ppe_pkg::CMD_WRITE) || (op.cmd == ppe_pkg::CMD_CYCLE);
    end

endmodule

`default_nettype wire

### design/packed_pixel_plane_editor.sv
// ----------------------------------------------------------------------------
// packed_pixel_plane_editor
// Pixel plane packed 1 or 2 bits per pixel in a byte RAM, edited by command.
//
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low; command, pos_x, pos_y and pixel_in are sampled there.
//   Result channel: done is high for exactly one cycle with pixel_out and
//   status valid; the receiver cannot stall it.
//   Config port: cfg_we writes cfg_data to register cfg_index (0 mode,
//   1 width, 2 height) at the clock edge; write only while busy is low.
// Sequencing:
//   Read, write and cycle: done rises as busy drops, so the next command
//   can be presented while the result is shown; each command passes the
//   multiply, address and RAM RMW steps in turn. Any error result skips
//   the RAM access and comes sooner. A clear command sweeps the whole RAM
//   one byte a cycle.
// Reset:
//   rst_n low sets registers to hires, 32x32; after release the RAM is
//   zeroed by a sweep of all MEM_BYTES bytes during which busy stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_plane_editor #(
    parameter int MEM_BYTES  = 8192,
    parameter int MAX_WIDTH  = 320,
    parameter int MAX_HEIGHT = 200
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // command channel
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] command,
    input  wire logic [8:0] pos_x,
    input  wire logic [7:0] pos_y,
    input  wire logic [1:0] pixel_in,
    // result channel
    output logic            done,
    output logic      [1:0] pixel_out,
    output logic      [1:0] status,
    // configuration port
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
    localparam logic [10:0]   WMAX_HIRES = 11'(MAX_WIDTH);
    localparam logic [10:0]   WMAX_MULTI = 11'(MAX_WIDTH / 2);
    localparam logic [10:0]   HMAX       = 11'(MAX_HEIGHT);
    localparam logic [16:0]   MEM_LIMIT  = 17'(MEM_BYTES);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CALC,
        S_CHECK,
        S_RMW,
        S_CLEAR
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       mode_reg;
    logic [8:0] width_reg;
    logic [7:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= 9'd32;
            height_reg <= 8'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppe_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                ppe_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                ppe_pkg::CFG_HEIGHT: height_reg <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            done_reg, done_next;
    logic [1:0]      pixel_reg, pixel_next;
    logic [1:0]      status_reg, status_next;

    ppe_pkg::cmd_t   cmd_reg;
    logic [8:0]      x_reg;
    logic [7:0]      y_reg;
    logic [1:0]      val_reg;
    logic [9:0]      bit_reg;
    logic [7:0]      stride_reg;
    logic [15:0]     dim_prod_reg;
    logic [15:0]     row_prod_reg;
    logic            dims_basic_reg;
    logic            coord_bad_reg;
    logic [AW-1:0]   addr_reg;

    logic            accept;
    logic [9:0]      bit_in;
    logic [10:0]     stride_sum;
    logic [10:0]     wmax;
    logic            dims_ok;
    logic [16:0]     addr_full;
    logic            val_bad;

    // RAM and pixel unit wiring
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;
    ppe_pkg::px_op_t alu_op;
    logic [7:0]      alu_byte;
    logic [1:0]      alu_pixel;
    logic            alu_wr;

    assign accept = start && !busy;

    // Stride, bit offset, bound checks and byte address from the current layout
    always_comb
    begin
        bit_in     = mode_reg ? {pos_x, 1'b0} : {1'b0, pos_x};
        stride_sum = (mode_reg ? {1'b0, width_reg, 1'b0} : {2'b00, width_reg}) + 11'd7;
        wmax       = mode_reg ? WMAX_MULTI : WMAX_HIRES;
        dims_ok    = dims_basic_reg && ({1'b0, dim_prod_reg} <= MEM_LIMIT);
        addr_full  = {1'b0, row_prod_reg} + {10'd0, bit_reg[9:3]};
        val_bad    = !mode_reg && val_reg[1];
    end

    // Payload pipeline: latch, multiply, then address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= ppe_pkg::cmd_t'(command);
            x_reg      <= pos_x;
            y_reg      <= pos_y;
            val_reg    <= pixel_in;
            bit_reg    <= bit_in;
            stride_reg <= stride_sum[10:3];
        end
        if (state_reg == S_CALC)
        begin
            dim_prod_reg   <= stride_reg * height_reg;
            row_prod_reg   <= stride_reg * y_reg;
            dims_basic_reg <= (width_reg != 9'd0) && ({2'b00, width_reg} <= wmax)
                              && (height_reg != 8'd0) && ({3'b000, height_reg} <= HMAX);
            coord_bad_reg  <= (x_reg >= width_reg) || (y_reg >= height_reg);
        end
        if (state_reg == S_CHECK)
        begin
            addr_reg <= addr_full[AW-1:0];
        end
    end

    // Next-state and result logic
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        pixel_next   = pixel_reg;
        status_next  = status_reg;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                    if (state_reg == S_CLEAR)
                    begin
                        done_next   = 1'b1;
                        pixel_next  = 2'd0;
                        status_next = ppe_pkg::ST_OK;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (!dims_ok)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    pixel_next  = 2'd0;
                    status_next = ppe_pkg::ST_DIMS;
                end
                else if (cmd_reg == ppe_pkg::CMD_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (coord_bad_reg)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    pixel_next  = 2'd0;
                    status_next = ppe_pkg::ST_COORD;
                end
                else if ((cmd_reg == ppe_pkg::CMD_WRITE) && val_bad)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    pixel_next  = 2'd0;
                    status_next = ppe_pkg::ST_VALUE;
                end
                else
                begin
                    state_next = S_RMW;
                end
            end
            S_RMW:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                pixel_next  = alu_pixel;
                status_next = ppe_pkg::ST_OK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State machine and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            pixel_reg   <= 2'd0;
            status_reg  <= ppe_pkg::ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            pixel_reg   <= pixel_next;
            status_reg  <= status_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign pixel_out = pixel_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // RAM port: sweep, read at check, write back at RMW
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = alu_byte;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 8'd0;
            end
            S_CHECK:
            begin
                ram_addr = addr_full[AW-1:0];
            end
            S_RMW:
            begin
                ram_we = alu_wr;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        alu_op.cmd        = cmd_reg;
        alu_op.multicolor = mode_reg;
        alu_op.shift      = (mode_reg ? ppe_pkg::SHIFT_BASE_MULTI : ppe_pkg::SHIFT_BASE_HIRES)
                            - bit_reg[2:0];
        alu_op.value      = val_reg;
    end

    ppe_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_plane_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ppe_pixel_alu u_pixel_alu (
        .op         (alu_op),
        .byte_in    (ram_rdata),
        .byte_out   (alu_byte),
        .pixel      (alu_pixel),
        .write_back (alu_wr)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding busy cycle");

    // A taken transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // Error results carry a zero pixel
    a_error_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ppe_pkg::ST_OK)) |-> (pixel_out == 2'd0))
        else $error("nonzero pixel on error result");

    // Sweep writes only zeros
    a_sweep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ((state_reg == S_INIT) || (state_reg == S_CLEAR))) |-> (ram_wdata == 8'd0))
        else $error("nonzero write during clear sweep");

    // No RAM write outside sweep or write-back
    a_we_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_INIT) || (state_reg == S_CLEAR) || (state_reg == S_RMW)))
        else $error("RAM write outside sweep or write-back");

endmodule

`default_nettype wire
